// File: src/lusp_pkg.sv
// Package for the LU solver with partial pivoting: payload structs, FSM states,
// sizes and Q16.16 saturation helpers. No dependencies.
`default_nettype none
package lusp_pkg;
  localparam int MAX_SIZE_DEF = 8;

  typedef struct packed {
    logic [2:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] entry_value;
    logic               load_done;
  } lusp_in_t;

  typedef struct packed {
    logic [2:0]         solution_index;
    logic signed [31:0] solution_value;
    logic               singular;
    logic               last_result;
  } lusp_out_t;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } lusp_div_state_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PV_RD, S_PV_CMP, S_SW_RDA, S_SW_RDB, S_SW_WRA, S_SW_WRB,
    S_CHK_RD, S_CHK, S_L_RD, S_L_DIV, S_L_WAIT, S_U_RD, S_U_MUL, S_U_PRD, S_U_WR,
    S_F_RD, S_F_LDA, S_F_LDB, S_F_PRD, S_F_ACC, S_F_WR,
    S_B_RD, S_B_LDA, S_B_PRD, S_B_ACC, S_B_RHS, S_B_DIV, S_B_WAIT,
    S_OUT_RD, S_OUT
  } lusp_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// File: src/lusp_div.sv
// Sequential Q16.16 divider: sat32((num * 2^16) / den), truncating toward zero.
// One quotient bit per cycle. Depends on lusp_pkg.
`default_nettype none
module lusp_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                    done,
  output logic signed [31:0]      quot
);
  import lusp_pkg::*;

  lusp_div_state_t state_r, state_nxt;
  logic [47:0] dvd_r, dvd_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] trial;
  logic [33:0] shifted;
  logic signed [65:0] sq;

  assign shifted = {rem_r, dvd_r[47]};
  assign trial   = shifted[32:0] - {1'b0, dvs_r};
  assign sq      = neg_r ? -$signed({18'd0, dvd_r}) : $signed({18'd0, dvd_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    dvd_nxt   = dvd_r;
    dvs_nxt   = dvs_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    done      = 1'b0;
    quot      = sat32(sq);
    unique case (state_r)
      DIV_IDLE: begin
        if (start) begin
          dvd_nxt   = {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
          dvs_nxt   = den[31] ? 32'(-den) : 32'(den);
          rem_nxt   = '0;
          cnt_nxt   = 6'd47;
          neg_nxt   = num[31] ^ den[31];
          state_nxt = DIV_RUN;
        end
      end
      DIV_RUN: begin
        // Restoring step: quotient bits shift into the dividend register.
        if (!trial[32] || shifted[33]) begin
          rem_nxt = trial;
          dvd_nxt = {dvd_r[46:0], 1'b1};
        end else begin
          rem_nxt = shifted[32:0];
          dvd_nxt = {dvd_r[46:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) state_nxt = DIV_DONE;
      end
      DIV_DONE: begin
        done      = 1'b1;
        state_nxt = DIV_IDLE;
      end
      default: state_nxt = DIV_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: src/lu_solve_partial_pivot.sv
// Top level of the LU solver with partial pivoting (Q16.16).
// Depends on lusp_pkg and lusp_div.
`default_nettype none
// Usage: write system_size with cfg_we/cfg_wdata while idle (reset value 8).
// Load entries with start: each accepted item (start & !busy) with row and
// column in range writes one entry of [A | b]; column n holds b. Loads are
// taken back to back. The item with load_done set starts the solve; busy
// stays high throughout it. The solve is sequenced over one shared 32x32
// multiplier and one bit-serial divider; matrix store reads are registered.
// Each eliminated row costs a division plus a multiply pass per updated
// entry, each forward step a multiply pass, each back-substitution row a
// division plus a multiply pass per product. Results follow: n items on
// consecutive cycles, each marked by out_valid for one cycle, x[0] first,
// last_result on x[n-1]; the next item is taken the cycle after that. The
// receiver cannot stall. A zero pivot gives singular = 1 and zero values.
// Reset clears control state; the matrix store is undefined until loaded.
module lu_solve_partial_pivot #(
  parameter int MAX_SIZE = lusp_pkg::MAX_SIZE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire lusp_pkg::lusp_in_t in_item,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_wdata,
  output logic                    out_valid,
  output lusp_pkg::lusp_out_t     out_item
);
  import lusp_pkg::*;

  localparam int NC = MAX_SIZE + 1;
  localparam int DEPTH = MAX_SIZE * NC;
  localparam int AW = $clog2(DEPTH);
  localparam int IW = $clog2(MAX_SIZE + 1);
  localparam int SW = $clog2(MAX_SIZE);

  lusp_state_t state_r, state_nxt;
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] sol [MAX_SIZE];
  logic signed [31:0] rd_r;
  logic signed [31:0] sol_rd_r;
  logic [AW-1:0] ra, wa;
  logic we;
  logic signed [31:0] wd;
  logic sol_we;
  logic [SW-1:0] sol_ra;
  logic [3:0] size_r;
  logic [IW-1:0] n, j_r, j_nxt, i_r, i_nxt, k_r, k_nxt, p_r, p_nxt;
  logic [32:0] best_r, best_nxt;
  logic signed [31:0] a_r, a_nxt, b_r, b_nxt, piv_r, piv_nxt;
  logic signed [63:0] prod_r;
  logic signed [65:0] acc_r, acc_nxt;
  logic sing_r, sing_nxt;
  logic div_start, div_done;
  logic signed [31:0] div_num, div_den, quot;
  logic [32:0] rmag;
  logic signed [47:0] qp;

  function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r * NC + c);
  endfunction

  always_comb begin
    if (size_r == 4'd0) n = IW'(1);
    else if (32'(size_r) > MAX_SIZE) n = IW'(MAX_SIZE);
    else n = IW'(size_r);
  end

  assign rmag = rd_r[31] ? 33'(-{rd_r[31], rd_r}) : {1'b0, rd_r};
  // Product truncates toward zero after the 16-bit shift.
  assign qp = 48'((prod_r + (prod_r[63] ? 64'sd65535 : 64'sd0)) >>> 16);

  lusp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
    if (sol_we) sol[i_r[SW-1:0]] <= quot;
    sol_rd_r <= sol[sol_ra];
    prod_r <= a_r * b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      size_r  <= 4'd8;
      sing_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sing_r  <= sing_nxt;
      if (cfg_we) size_r <= cfg_wdata;
    end
    j_r <= j_nxt; i_r <= i_nxt; k_r <= k_nxt; p_r <= p_nxt;
    best_r <= best_nxt; a_r <= a_nxt; b_r <= b_nxt; piv_r <= piv_nxt;
    acc_r <= acc_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt = j_r; i_nxt = i_r; k_nxt = k_r; p_nxt = p_r;
    best_nxt = best_r; a_nxt = a_r; b_nxt = b_r; piv_nxt = piv_r; acc_nxt = acc_r;
    sing_nxt = sing_r;
    ra = '0; wa = '0; we = 1'b0; wd = rd_r; sol_we = 1'b0; sol_ra = i_r[SW-1:0];
    div_start = 1'b0; div_num = a_r; div_den = piv_r;
    busy = (state_r != S_IDLE);
    out_valid = 1'b0;
    out_item.solution_index = 3'(i_r);
    out_item.solution_value = sing_r ? 32'sd0 : sol_rd_r;
    out_item.singular = sing_r;
    out_item.last_result = (i_r == n - IW'(1));
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (32'(in_item.row_index) < MAX_SIZE && 32'(in_item.col_index) <= MAX_SIZE) begin
            we = 1'b1;
            wa = addr(IW'(in_item.row_index), IW'(in_item.col_index));
            wd = in_item.entry_value;
          end
          if (in_item.load_done) begin
            sing_nxt = 1'b0; j_nxt = '0; i_nxt = '0; p_nxt = '0; best_nxt = '0;
            state_nxt = S_PV_RD;
          end
        end
      end
      // Pivot search: i runs j..n-1 over column j.
      S_PV_RD: begin ra = addr(i_r, j_r); state_nxt = S_PV_CMP; end
      S_PV_CMP: begin
        if (i_r == j_r || rmag > best_r) begin best_nxt = rmag; p_nxt = i_r; end
        if (i_r == n - IW'(1)) begin k_nxt = '0; state_nxt = S_SW_RDA; end
        else begin i_nxt = i_r + IW'(1); state_nxt = S_PV_RD; end
        if (i_r == n - IW'(1) && !(rmag > best_r) && p_r == j_r && i_r != j_r)
          state_nxt = S_CHK_RD;
        if (i_r == n - IW'(1) && i_r == j_r) state_nxt = S_CHK_RD;
      end
      S_SW_RDA: begin ra = addr(j_r, k_r); state_nxt = S_SW_RDB; end
      S_SW_RDB: begin ra = addr(p_r, k_r); a_nxt = rd_r; state_nxt = S_SW_WRA; end
      S_SW_WRA: begin we = 1'b1; wa = addr(j_r, k_r); wd = rd_r; state_nxt = S_SW_WRB; end
      S_SW_WRB: begin
        we = 1'b1; wa = addr(p_r, k_r); wd = a_r;
        if (k_r == n) state_nxt = S_CHK_RD;
        else begin k_nxt = k_r + IW'(1); state_nxt = S_SW_RDA; end
      end
      S_CHK_RD: begin ra = addr(j_r, j_r); state_nxt = S_CHK; end
      S_CHK: begin
        piv_nxt = rd_r;
        i_nxt = j_r + IW'(1);
        if (rd_r == 32'sd0) begin
          sing_nxt = 1'b1; i_nxt = '0; state_nxt = S_OUT_RD;
        end else if (j_r == n - IW'(1)) begin
          acc_nxt = '0; k_nxt = '0;
          if (n == IW'(1)) begin
            i_nxt = '0; k_nxt = n; state_nxt = S_B_RD;
          end else begin
            i_nxt = IW'(1); state_nxt = S_F_RD;
          end
        end else state_nxt = S_L_RD;
      end
      S_L_RD: begin ra = addr(i_r, j_r); state_nxt = S_L_DIV; end
      S_L_DIV: begin
        div_start = 1'b1; div_num = rd_r; div_den = piv_r; state_nxt = S_L_WAIT;
      end
      S_L_WAIT: if (div_done) begin
        we = 1'b1; wa = addr(i_r, j_r); wd = quot; a_nxt = quot;
        k_nxt = j_r + IW'(1); state_nxt = S_U_RD;
      end
      // Row update: u[i][k] -= l * u[j][k], one k per pass.
      S_U_RD: begin
        if (k_r == n) begin
          if (i_r == n - IW'(1)) begin
            j_nxt = j_r + IW'(1); i_nxt = j_r + IW'(1); state_nxt = S_PV_RD;
          end else begin i_nxt = i_r + IW'(1); state_nxt = S_L_RD; end
        end else begin ra = addr(j_r, k_r); state_nxt = S_U_MUL; end
      end
      S_U_MUL: begin b_nxt = rd_r; state_nxt = S_U_PRD; end
      // The product register loads l * u[j][k] at the end of this cycle.
      S_U_PRD: begin ra = addr(i_r, k_r); state_nxt = S_U_WR; end
      S_U_WR: begin
        state_nxt = S_U_RD;
        we = 1'b1; wa = addr(i_r, k_r);
        wd = sat32(66'(rd_r) - 66'(qp));
        k_nxt = k_r + IW'(1);
      end
      S_F_RD: begin
        if (k_r == i_r) begin ra = addr(i_r, n); state_nxt = S_F_WR; end
        else begin ra = addr(i_r, k_r); state_nxt = S_F_LDA; end
      end
      S_F_LDA: begin a_nxt = rd_r; ra = addr(k_r, n); state_nxt = S_F_LDB; end
      S_F_LDB: begin b_nxt = rd_r; state_nxt = S_F_PRD; end
      S_F_PRD: state_nxt = S_F_ACC;
      S_F_ACC: begin
        acc_nxt = acc_r + 66'(qp); k_nxt = k_r + IW'(1); state_nxt = S_F_RD;
      end
      S_F_WR: begin
        we = 1'b1; wa = addr(i_r, n); wd = sat32(66'(rd_r) - acc_r);
        acc_nxt = '0; k_nxt = '0;
        if (i_r == n - IW'(1)) begin
          i_nxt = n - IW'(1); k_nxt = n; state_nxt = S_B_RD;
        end else begin i_nxt = i_r + IW'(1); state_nxt = S_F_RD; end
      end
      S_B_RD: begin
        sol_ra = k_r[SW-1:0];
        if (k_r == n) begin ra = addr(i_r, n); state_nxt = S_B_RHS; end
        else begin ra = addr(i_r, k_r); state_nxt = S_B_LDA; end
      end
      S_B_LDA: begin a_nxt = rd_r; b_nxt = sol_rd_r; state_nxt = S_B_PRD; end
      S_B_PRD: state_nxt = S_B_ACC;
      S_B_ACC: begin
        acc_nxt = acc_r + 66'(qp); k_nxt = k_r + IW'(1); state_nxt = S_B_RD;
      end
      S_B_RHS: begin
        a_nxt = sat32(66'(rd_r) - acc_r); ra = addr(i_r, i_r); state_nxt = S_B_DIV;
      end
      S_B_DIV: begin
        div_start = 1'b1; div_num = a_r; div_den = rd_r; state_nxt = S_B_WAIT;
      end
      S_B_WAIT: if (div_done) begin
        sol_we = 1'b1; acc_nxt = '0;
        if (i_r == '0) state_nxt = S_OUT_RD;
        else begin i_nxt = i_r - IW'(1); k_nxt = i_r; state_nxt = S_B_RD; end
      end
      // S_OUT_RD fetches x[0] before the results stream out.
      S_OUT_RD: state_nxt = S_OUT;
      S_OUT: begin
        out_valid = 1'b1;
        sol_ra = SW'(i_r + IW'(1));
        if (i_r == n - IW'(1)) state_nxt = S_IDLE;
        else i_nxt = i_r + IW'(1);
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  property p_out_only_when_solving;
    @(posedge clk) disable iff (!rst_n) out_valid |-> busy;
  endproperty
  a_out_busy: assert property (p_out_only_when_solving) else $error("result outside solve");

  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_result |=> !busy) else $error("solve did not end");

  a_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !we || state_r != S_IDLE) else $error("load while busy");
endmodule
`default_nettype wire

// File: dv/lu_solve_partial_pivot_tb.sv
// Testbench for lu_solve_partial_pivot: loads augmented systems, predicts the
// Q16.16 solution vector in a scoreboard class and checks every result item.
// Depends on lusp_pkg and the solver RTL.
`timescale 1ns / 100ps

class lusp_scoreboard;
  int signed   mat [8][9];
  bit          written [8][9];
  int unsigned size_reg = 8;
  lusp_pkg::lusp_out_t solution_q[$];
  int unsigned mismatches = 0;

  function int eff_size();
    if (size_reg < 1) return 1;
    if (size_reg > 8) return 8;
    return size_reg;
  endfunction

  function int signed clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function longint qprod(int signed a, int signed b);
    return (longint'(a) * longint'(b)) / 65536;
  endfunction

  function int signed qquot(int signed num, int signed den);
    return clamp32((longint'(num) * 65536) / longint'(den));
  endfunction

  function longint absval(int signed v);
    longint w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  // Gaussian elimination with row pivoting on the stored system, in place.
  function void solve_system(int n);
    int signed x [8];
    int piv;
    int signed t, l;
    longint best, acc;
    bit sing;
    sing = 0;
    for (int j = 0; j < n && !sing; j++) begin
      piv = j;
      best = absval(mat[j][j]);
      for (int i = j + 1; i < n; i++) begin
        if (absval(mat[i][j]) > best) begin
          best = absval(mat[i][j]);
          piv = i;
        end
      end
      if (piv != j) begin
        for (int k = 0; k <= n; k++) begin
          t = mat[j][k];
          mat[j][k] = mat[piv][k];
          mat[piv][k] = t;
        end
      end
      if (mat[j][j] == 0) begin
        sing = 1;
      end else begin
        for (int i = j + 1; i < n; i++) begin
          l = qquot(mat[i][j], mat[j][j]);
          mat[i][j] = l;
          for (int k = j + 1; k < n; k++)
            mat[i][k] = clamp32(longint'(mat[i][k]) - qprod(l, mat[j][k]));
        end
      end
    end
    for (int i = 0; i < 8; i++) x[i] = 0;
    if (!sing) begin
      for (int i = 1; i < n; i++) begin
        acc = 0;
        for (int k = 0; k < i; k++) acc += qprod(mat[i][k], mat[k][n]);
        mat[i][n] = clamp32(longint'(mat[i][n]) - acc);
      end
      for (int i = n - 1; i >= 0; i--) begin
        acc = 0;
        for (int k = i + 1; k < n; k++) acc += qprod(mat[i][k], x[k]);
        x[i] = qquot(clamp32(longint'(mat[i][n]) - acc), mat[i][i]);
      end
    end
    for (int i = 0; i < n; i++) begin
      lusp_pkg::lusp_out_t r;
      r.solution_index = i[2:0];
      r.solution_value = x[i];
      r.singular       = sing;
      r.last_result    = (i == n - 1);
      solution_q.push_back(r);
    end
  endfunction

  function void note_entry(lusp_pkg::lusp_in_t it);
    if (it.col_index <= 8) begin
      mat[it.row_index][it.col_index] = it.entry_value;
      written[it.row_index][it.col_index] = 1;
    end
    if (it.load_done) solve_system(eff_size());
  endfunction

  function bit system_loaded();
    int n;
    n = eff_size();
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= n; c++)
        if (!written[r][c]) return 0;
    return 1;
  endfunction

  function void check_solution(lusp_pkg::lusp_out_t got);
    lusp_pkg::lusp_out_t exp_r;
    if (solution_q.size() == 0) begin
      $display("%0t: unexpected result item %p", $time, got);
      mismatches++;
      return;
    end
    exp_r = solution_q.pop_front();
    if (got.solution_index !== exp_r.solution_index) begin
      $display("%0t: solution_index expected %0d actual %0d", $time,
               exp_r.solution_index, got.solution_index);
      mismatches++;
    end
    if (got.solution_value !== exp_r.solution_value) begin
      $display("%0t: solution_value[%0d] expected %h actual %h", $time,
               exp_r.solution_index, exp_r.solution_value, got.solution_value);
      mismatches++;
    end
    if (got.singular !== exp_r.singular) begin
      $display("%0t: singular expected %b actual %b", $time,
               exp_r.singular, got.singular);
      mismatches++;
    end
    if (got.last_result !== exp_r.last_result) begin
      $display("%0t: last_result expected %b actual %b", $time,
               exp_r.last_result, got.last_result);
      mismatches++;
    end
  endfunction
endclass

module lu_solve_partial_pivot_tb;
  import lusp_pkg::*;

  localparam int IDLE_LIMIT = 200000;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  logic      busy;
  lusp_in_t  in_item = '0;
  logic      cfg_we = 0;
  logic [3:0] cfg_wdata = '0;
  logic      out_valid;
  lusp_out_t out_item;

  lusp_scoreboard sb = new();
  int  loaded_items = 0;
  int  quiet_cycles = 0;
  bit  no_gaps = 0;
  bit  big_done = 0;

  lu_solve_partial_pivot dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .out_valid(out_valid),
    .out_item(out_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_solution(out_item);
    if (rst_n && (out_valid || (start && !busy))) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_entry(int r, int c, int signed v, bit done);
    lusp_in_t it;
    it.row_index = r[2:0];
    it.col_index = c[3:0];
    it.entry_value = v;
    it.load_done = done;
    @(negedge clk);
    start = 1;
    in_item = it;
    do @(posedge clk); while (busy);
    sb.note_entry(it);
    loaded_items++;
    if (!no_gaps && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      start = 0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
  endtask

  task automatic write_size(int unsigned v);
    @(negedge clk);
    start = 0;
    while (sb.solution_q.size() != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v[3:0];
    @(negedge clk);
    cfg_we = 0;
    sb.size_reg = v;
  endtask

  function automatic int signed pick_value(int kind, int r, int c);
    int signed corner [5] = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh10000, -1};
    case (kind)
      0: return $signed($urandom_range(0, 20'hfffff)) - 32'sh80000;
      1: return $urandom();
      2: return corner[$urandom_range(0, 4)];
      3: return (c == 0) ? 0 : $urandom();
      default: return (r == c) ? 0 : 32'sh10000 * (r + c + 1);
    endcase
  endfunction

  // Loads the full augmented system in row order; the last entry starts the solve.
  task automatic load_system(int kind);
    int n;
    n = sb.eff_size();
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= n; c++)
        send_entry(r, c, pick_value(kind, r, c), (r == n - 1) && (c == n));
  endtask

  // Rewrites a few entries of an already loaded system, with ignored writes mixed in.
  task automatic reload_some();
    int n;
    n = sb.eff_size();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 2) == 0)
        send_entry($urandom_range(0, 7), $urandom_range(9, 15), $urandom(), 0);
      else
        send_entry($urandom_range(0, n - 1), $urandom_range(0, n), $urandom(), 0);
    end
    send_entry($urandom_range(0, 7), $urandom_range(0, 15), pick_value(0, 0, 1), 1);
  endtask

  initial begin
    int unsigned sz;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: swap needed, singular, extremes, ties, size limits.
    write_size(2);
    load_system(4);
    send_entry(0, 0, 0, 0);
    send_entry(1, 0, 0, 1);
    send_entry(0, 0, 32'sh10000, 0);
    send_entry(1, 0, -32'sh10000, 0);
    send_entry(1, 1, 32'sh10000, 0);
    send_entry(3, 12, 32'sh7fffffff, 1);
    write_size(1);
    send_entry(0, 0, 32'sh80000000, 0);
    send_entry(0, 1, 32'sh7fffffff, 1);
    send_entry(0, 0, 1, 0);
    send_entry(0, 1, 32'sh80000000, 1);
    write_size(0);
    send_entry(0, 0, 0, 1);
    write_size(3);
    load_system(2);

    while (loaded_items < 170) begin
      if (loaded_items > 140) no_gaps = 1;
      if ($urandom_range(0, 2) == 0) begin
        sz = $urandom_range(0, 7);
        if (sz == 7 && !big_done) begin
          sz = ($urandom_range(0, 1) == 0) ? 8 : 15;
          big_done = 1;
        end else if (sz == 7) begin
          sz = 2;
        end
        write_size(sz);
      end
      if (sb.system_loaded() && $urandom_range(0, 3) == 0) reload_some();
      else load_system(($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 4));
    end

    @(negedge clk);
    start = 0;
    while (sb.solution_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
